@@ rtl/smo_pkg.sv @@
// Shared constants and types for the stack machine block.
`timescale 1ns / 1ps
`default_nettype none

package smo_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int MAX_RESULTS = 32;
   localparam int WORD_W      = 32;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      OP_PUSH      = 3'd0,
      OP_PRINT_ALL = 3'd1,
      OP_PRINT_TOP = 3'd2,
      OP_SWAP      = 3'd3,
      OP_ADD       = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_SHORT  = 3'd2,
      ST_FULL   = 3'd3,
      ST_HALTED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD_B,
      S_OP,
      S_WR2,
      S_PTOP,
      S_PALL,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

@@ rtl/smo_ifs.sv @@
// Valid/ready channel interfaces for the opcode and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface smo_req_if import smo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

interface smo_rsp_if import smo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] word;
   logic [STATUS_W-1:0]      status;
   logic                     last;

   modport source (output valid, output word, output status, output last, input ready);
   modport sink (input valid, input word, input status, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/smo_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module smo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/stack_machine_ops.sv @@
// Top level of the stack machine: sequencer, stack RAM and result register.
//
//   channel   | dir | beat fields          | handshake
//   ----------+-----+----------------------+-------------
//   req_chan  | in  | kind, value          | valid/ready
//   rsp_chan  | out | word, status, last   | valid/ready
//
// With one read and one write port on the stack RAM, push writes from S_EXEC; swap and add
// read the top in S_EXEC and the entry below in S_RD_B, then write in S_OP (and S_WR2 for swap);
// print top, print all, errors and halted send beats from S_PTOP, S_PALL, S_EMIT, waiting on rsp_chan stalls.
// Reset clears the entry count, the halted flag and the result valid flag.
// The next opcode is taken while a result beat still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_ops import smo_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   smo_req_if.sink   req_chan,
   smo_rsp_if.source rsp_chan
);

   state_type                state_ff, state_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic signed [WORD_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     halted_ff, halted_in;
   status_type               status_ff, status_in;
   logic [WORD_W-1:0]        a_ff, a_in;
   logic [WORD_W-1:0]        b_ff, b_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [CNT_W-1:0]         left_ff, left_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic              out_free;
   logic              fail_en;
   status_type        fail_code;
   logic [ADDR_W-1:0] top_addr;
   logic [ADDR_W-1:0] below_addr;
   logic [CNT_W-1:0]  print_count;

   smo_ram #(
      .WIDTH(WORD_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign top_addr    = ADDR_W'(count_ff - CNT_W'(1));
   assign below_addr  = ADDR_W'(count_ff - CNT_W'(2));
   assign print_count = (count_ff > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : count_ff;

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.word   = rsp_word_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.last   = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      halted_in     = halted_ff;
      status_in     = status_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      addr_in       = addr_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      req_chan.ready = 1'b0;
      fail_en       = 1'b0;
      fail_code     = ST_OK;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               kind_in  = req_chan.kind;
               value_in = req_chan.value;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_IDLE;
            if (halted_ff) begin
               status_in = ST_HALTED;
               state_in  = S_EMIT;
            end else begin
               case (opcode_type'(kind_ff))
                  OP_PUSH: begin
                     if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                        fail_en   = 1'b1;
                        fail_code = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = ADDR_W'(count_ff);
                        wr_data  = value_ff;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PRINT_ALL: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        addr_in  = top_addr;
                        left_in  = print_count;
                        state_in = S_PALL;
                     end
                  end
                  OP_PRINT_TOP: begin
                     if (count_ff == '0) begin
                        fail_en   = 1'b1;
                        fail_code = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        state_in = S_PTOP;
                     end
                  end
                  OP_SWAP, OP_ADD: begin
                     if (count_ff < CNT_W'(2)) begin
                        fail_en   = 1'b1;
                        fail_code = ST_SHORT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        state_in = S_RD_B;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_RD_B: begin
            a_in     = rd_data;
            rd_en    = 1'b1;
            rd_addr  = below_addr;
            state_in = S_OP;
         end

         S_OP: begin
            wr_en   = 1'b1;
            wr_addr = below_addr;
            if (opcode_type'(kind_ff) == OP_ADD) begin
               // The sum replaces the second entry and the top is dropped.
               wr_data  = a_ff + rd_data;
               count_in = count_ff - CNT_W'(1);
               state_in = S_IDLE;
            end else begin
               wr_data  = a_ff;
               b_in     = rd_data;
               state_in = S_WR2;
            end
         end

         S_WR2: begin
            wr_en    = 1'b1;
            wr_addr  = top_addr;
            wr_data  = b_ff;
            state_in = S_IDLE;
         end

         S_PTOP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = rd_data;
               rsp_status_in = ST_OK;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_PALL: begin
            // The RAM read data holds while the output register is stalled.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = rd_data;
               rsp_status_in = ST_OK;
               rsp_last_in   = (left_ff == CNT_W'(1));
               if (left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = addr_ff - ADDR_W'(1);
                  addr_in = addr_ff - ADDR_W'(1);
                  left_in = left_ff - CNT_W'(1);
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = '0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fail_en) begin
         halted_in = 1'b1;
         count_in  = '0;
         status_in = fail_code;
         state_in  = S_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      addr_ff       <= addr_in;
      left_ff       <= left_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("entry count above stack depth");

   a_halt_clears: assert property (@(posedge clock) disable iff (reset)
      $rose(halted_ff) |-> (count_ff == '0))
      else $error("stack not cleared on error");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_word_ff == '0 && rsp_last_ff))
      else $error("error beat carries a word or is not last");

endmodule

`default_nettype wire

@@ test/stack_machine_ops_tb.sv @@
// Self-checking testbench for the stack machine: random opcode beats checked against a predictor.
`timescale 1ns / 1ps

module stack_machine_ops_tb;
   import smo_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 400_000;
   localparam int unsigned OPS_PER_PHASE   = 56;
   localparam int unsigned DRAIN_CYCLES    = 80;
   localparam int unsigned HALTED_TAIL_OPS = 8;
   localparam int unsigned REPORT_LIMIT    = 10;
   localparam int FIRST_UNUSED_KIND = int'(OP_ADD) + 1;
   localparam int LAST_UNUSED_KIND  = (1 << KIND_W) - 1;

   typedef struct {
      logic signed [WORD_W-1:0] word;
      status_type               status;
      logic                     last;
   } result_beat_type;

   // Tracks the stack contents and holds the result beats still owed by the block.
   class stack_scoreboard;
      logic signed [WORD_W-1:0] words [STACK_DEPTH];
      int unsigned              depth = 0;
      bit                       halted = 1'b0;
      result_beat_type          pending [$];
      int unsigned              faults = 0;

      function void owe(logic signed [WORD_W-1:0] word, status_type status, logic last);
         result_beat_type b;
         b.word = word;
         b.status = status;
         b.last = last;
         pending.push_back(b);
      endfunction

      function void halt_with(status_type code);
         depth = 0;
         halted = 1'b1;
         owe('0, code, 1'b1);
      endfunction

      function void note_op(logic [KIND_W-1:0] kind, logic signed [WORD_W-1:0] value);
         int unsigned shown;
         int unsigned i;
         logic signed [WORD_W-1:0] top;
         if (halted) begin
            owe('0, ST_HALTED, 1'b1);
            return;
         end
         case (kind)
            OP_PUSH: begin
               if (depth >= STACK_DEPTH) begin
                  halt_with(ST_FULL);
               end else begin
                  words[depth] = value;
                  depth++;
               end
            end
            OP_PRINT_ALL: begin
               shown = (depth > MAX_RESULTS) ? MAX_RESULTS : depth;
               for (i = 0; i < shown; i++)
                  owe(words[depth - 1 - i], ST_OK, (i + 1 == shown));
            end
            OP_PRINT_TOP: begin
               if (depth == 0) halt_with(ST_EMPTY);
               else owe(words[depth - 1], ST_OK, 1'b1);
            end
            OP_SWAP: begin
               if (depth < 2) begin
                  halt_with(ST_SHORT);
               end else begin
                  top = words[depth - 1];
                  words[depth - 1] = words[depth - 2];
                  words[depth - 2] = top;
               end
            end
            OP_ADD: begin
               if (depth < 2) begin
                  halt_with(ST_SHORT);
               end else begin
                  words[depth - 2] = words[depth - 1] + words[depth - 2];
                  depth--;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_beat(logic signed [WORD_W-1:0] word, logic [STATUS_W-1:0] status,
                               logic last);
         result_beat_type want;
         if (pending.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("unexpected result beat: word %0d status %0d last %0d",
                        word, status, last);
            return;
         end
         want = pending.pop_front();
         if (word !== want.word || status !== want.status || last !== want.last) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display({"mismatch: expected word %0d status %0d last %0d,",
                         " got word %0d status %0d last %0d"},
                        want.word, want.status, want.last, word, status, last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   stack_scoreboard sb = new();

   smo_req_if req_if ();
   smo_rsp_if rsp_if ();

   stack_machine_ops dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: check every accepted beat, then decide whether to stall next cycle.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_beat(rsp_if.word, rsp_if.status, rsp_if.last);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0: pick_word = 32'sh7fffffff;
         1: pick_word = 32'sh80000000;
         2: pick_word = '0;
         3: pick_word = '1;
         default: pick_word = $urandom;
      endcase
   endfunction

   // Valid stays high from one beat to the next unless an idle gap is drawn.
   task send_op(input logic [KIND_W-1:0] kind, input logic signed [WORD_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_op(kind, value);
   endtask

   task wait_until_settled();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Keeps the stack out of error cases; arbitrary kinds when halted, and unused kinds when not halted too.
   task send_random_op(output bit counted);
      logic [KIND_W-1:0] kind;
      int unsigned       roll;
      int unsigned       floor_depth;
      roll = $urandom_range(99);
      counted = 1'b1;
      if (sb.halted) begin
         kind = KIND_W'($urandom);
      end else if (roll < 40) begin
         kind = (sb.depth >= STACK_DEPTH) ? OP_ADD : OP_PUSH;
      end else if (roll < 52) begin
         kind = (sb.depth == 0) ? OP_PUSH : OP_PRINT_TOP;
      end else if (roll < 64) begin
         kind = (sb.depth < 2) ? OP_PUSH : OP_SWAP;
      end else if (roll < 80) begin
         kind = (sb.depth < 2) ? OP_PUSH : OP_ADD;
      end else if (roll < 92) begin
         kind = OP_PRINT_ALL;
      end else if (roll < 96) begin
         // Fold the stack down to a few entries so shallow stacks get exercised too.
         floor_depth = $urandom_range(3, 1);
         while (sb.depth > floor_depth) send_op(OP_ADD, pick_word());
         kind = OP_PRINT_ALL;
      end else begin
         kind = KIND_W'($urandom_range(LAST_UNUSED_KIND, FIRST_UNUSED_KIND));
         counted = 1'b0;
      end
      send_op(kind, pick_word());
   endtask

   initial begin
      int unsigned sent;
      int unsigned k;
      bit          counted;
      int unsigned idle_by_phase [4];
      int unsigned stall_by_phase [4];
      idle_by_phase  = '{0, 63, 0, 9};
      stall_by_phase = '{0, 0, 63, 9};
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.kind  <= OP_PUSH;
      req_if.value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // An empty stack can only be seen before the first push, so now and then a run
      // opens with print top on it and spends the rest in the halted state.
      if ($urandom_range(7) == 0) send_op(OP_PRINT_TOP, pick_word());
      send_op(OP_PRINT_ALL, pick_word());
      for (k = FIRST_UNUSED_KIND; k <= LAST_UNUSED_KIND; k++) send_op(KIND_W'(k), '1);
      send_op(OP_PUSH, 32'sh7fffffff);
      send_op(OP_PUSH, 32'sh00000001);
      send_op(OP_ADD, '1);
      send_op(OP_PRINT_TOP, '0);
      send_op(OP_PUSH, 32'sh80000000);
      send_op(OP_PUSH, '1);
      send_op(OP_PRINT_ALL, pick_word());
      send_op(OP_SWAP, pick_word());
      send_op(OP_PRINT_ALL, pick_word());
      send_op(OP_ADD, pick_word());
      send_op(OP_PUSH, '0);
      send_op(OP_SWAP, pick_word());
      send_op(OP_PRINT_TOP, pick_word());
      send_op(OP_ADD, pick_word());
      send_op(OP_PRINT_ALL, pick_word());
      wait_until_settled();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_by_phase[p];
         stall_pct     = stall_by_phase[p];
         sent = 0;
         while (sent < OPS_PER_PHASE) begin
            send_random_op(counted);
            if (counted) sent++;
         end
         wait_until_settled();
      end

      // Unless already halted, finish with one error of a random kind, then show that the block stays halted.
      if (!sb.halted) begin
         case ($urandom_range(2))
            0: begin
               while (sb.depth > 1) send_op(OP_ADD, pick_word());
               send_op(OP_SWAP, pick_word());
            end
            1: begin
               while (sb.depth > 1) send_op(OP_ADD, pick_word());
               send_op(OP_ADD, pick_word());
            end
            default: begin
               while (sb.depth < STACK_DEPTH) send_op(OP_PUSH, pick_word());
               send_op(OP_PUSH, pick_word());
            end
         endcase
      end
      repeat (HALTED_TAIL_OPS) send_op(KIND_W'($urandom), pick_word());
      wait_until_settled();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.faults == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
